>>> hdl/box_blur_3x3_edge_mean_assert.svh
// Assertion macros for the 3x3 box blur block.
`ifndef BOX_BLUR_3X3_EDGE_MEAN_ASSERT_SVH
`define BOX_BLUR_3X3_EDGE_MEAN_ASSERT_SVH
`ifndef SYNTHESIS
// Checked while out of reset; clock and reset are named clock and reset.
`define BBM_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("bbm assertion failed");
// Checked at every edge, reset included.
`define BBM_ASSERT_ALL(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("bbm assertion failed");
`else
`define BBM_ASSERT(label, prop)
`define BBM_ASSERT_ALL(label, prop)
`endif
`endif

>>> hdl/bbm_pkg.sv
// Shared types, constants and functions of the 3x3 box blur.
`timescale 1ns / 1ps
package bbm_pkg;
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 4096;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT + 1);
   localparam int FW_W       = 11;
   localparam int FH_W       = 13;
   localparam int PIX_W      = 24;
   localparam int OPQ_DEPTH  = 4;
   localparam int OUT_DEPTH  = 8;
   localparam int RECIP_W    = 17;
   localparam int SUM_W      = 12;

   localparam logic       REQ_PIXEL        = 1'b0;
   localparam logic       REQ_DRAIN        = 1'b1;
   localparam logic [0:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [0:0] CSR_FRAME_HEIGHT = 1'b1;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic [COL_W-1:0] col;
      logic             has_res;
      logic             left_ok;
      logic             right_ok;
      logic             top_ok;
      logic             bot_ok;
      logic             row_end;
      logic             frame_end;
   } op_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       row_end;
      logic       frame_end;
   } res_type;

   typedef struct packed {
      logic [$clog2(OUT_DEPTH+1)-1:0] pend_cnt;
      logic [$clog2(OUT_DEPTH+1)-1:0] fifo_cnt;
   } status_type;

   // ceil(2^16 / n) for the neighbor counts that can occur
   function automatic logic [RECIP_W-1:0] recip(input logic [3:0] n);
      logic [RECIP_W-1:0] m;
      case (n)
         4'd2:    m = 17'd32768;
         4'd3:    m = 17'd21846;
         4'd4:    m = 17'd16384;
         4'd6:    m = 17'd10923;
         4'd9:    m = 17'd7282;
         default: m = 17'd65536;
      endcase
      return m;
   endfunction
endpackage

>>> hdl/bbm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module bbm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [0:DEPTH-1];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

>>> hdl/bbm_front.sv
// Front end: frame position tracking, item classification and op queue.
`timescale 1ns / 1ps
module bbm_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [bbm_pkg::FW_W-1:0]  frame_width,
   input  logic [bbm_pkg::FH_W-1:0]  frame_height,
   input  logic                      restart,
   input  logic                      req_push,
   output logic                      req_full,
   input  logic                      req_type,
   input  logic [7:0]                req_in_red,
   input  logic [7:0]                req_in_green,
   input  logic [7:0]                req_in_blue,
   output logic                      op_valid,
   output bbm_pkg::op_type           op,
   input  logic                      op_pop
);
   localparam int QPW = $clog2(bbm_pkg::OPQ_DEPTH);
   localparam int QCW = $clog2(bbm_pkg::OPQ_DEPTH + 1);

   logic [bbm_pkg::COL_W-1:0] in_col_ff, in_col_in;
   logic [bbm_pkg::ROW_W-1:0] in_row_ff, in_row_in;
   logic                      pend_ff, pend_in;
   bbm_pkg::op_type           q_ff [0:bbm_pkg::OPQ_DEPTH-1];
   logic [QPW-1:0]            wr_ptr_ff, rd_ptr_ff;
   logic [QCW-1:0]            cnt_ff;

   logic accept, is_drain, frame_done, q_full, adv_go, x0;
   logic [bbm_pkg::ROW_W-1:0] orow;
   logic [bbm_pkg::FW_W-1:0]  ocol, col_inc;
   bbm_pkg::op_type           adv;

   assign q_full     = (cnt_ff == QCW'(bbm_pkg::OPQ_DEPTH));
   assign req_full   = pend_ff | q_full;
   assign accept     = req_push & ~req_full;
   assign is_drain   = (req_type == bbm_pkg::REQ_DRAIN);
   assign frame_done = (in_row_ff >= frame_height);
   assign adv_go     = pend_ff ? ~q_full : (accept & (is_drain == frame_done));

   always_comb begin
      x0      = (in_col_ff == '0);
      orow    = x0 ? in_row_ff - 13'd2 : in_row_ff - 13'd1;
      ocol    = x0 ? frame_width - 11'd1 : {1'b0, in_col_ff} - 11'd1;
      col_inc = {1'b0, in_col_ff} + 11'd1;
      adv.pixel     = (pend_ff | is_drain) ? '0 : {req_in_red, req_in_green, req_in_blue};
      adv.col       = in_col_ff;
      adv.has_res   = x0 ? (in_row_ff >= 13'd2) : (in_row_ff >= 13'd1);
      adv.left_ok   = x0 ? (frame_width >= 11'd2) : (in_col_ff >= 10'd2);
      adv.right_ok  = ~x0;
      adv.top_ok    = (orow != '0);
      adv.bot_ok    = ({1'b0, orow} + 14'd1) < {1'b0, frame_height};
      adv.row_end   = ((ocol + 11'd1) == frame_width);
      adv.frame_end = adv.row_end && (({1'b0, orow} + 14'd1) == {1'b0, frame_height});
   end

   always_comb begin
      in_col_in = in_col_ff;
      in_row_in = in_row_ff;
      pend_in   = pend_ff;
      if (restart) begin
         in_col_in = '0;
         in_row_in = '0;
         pend_in   = 1'b0;
      end else if (adv_go) begin
         // a drain on a one-row frame first steps over a position with no result
         pend_in = ~pend_ff & is_drain & ~adv.has_res;
         if (adv.has_res && adv.frame_end) begin
            in_col_in = '0;
            in_row_in = '0;
         end else if (col_inc >= frame_width) begin
            in_col_in = '0;
            in_row_in = in_row_ff + 13'd1;
         end else begin
            in_col_in = col_inc[bbm_pkg::COL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff <= '0;
         in_row_ff <= '0;
         pend_ff   <= 1'b0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         in_col_ff <= in_col_in;
         in_row_ff <= in_row_in;
         pend_ff   <= pend_in;
         if (adv_go) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (op_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         cnt_ff <= cnt_ff + QCW'(adv_go) - QCW'(op_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (adv_go) begin
         q_ff[wr_ptr_ff] <= adv;
      end
   end

   assign op_valid = (cnt_ff != '0);
   assign op       = q_ff[rd_ptr_ff];
endmodule

>>> hdl/bbm_back.sv
// Back end: line buffers, 3x3 window, border-aware mean and result queue.
`timescale 1ns / 1ps
module bbm_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                op_valid,
   input  bbm_pkg::op_type     op,
   output logic                op_pop,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output bbm_pkg::res_type    rsp,
   output bbm_pkg::status_type status
);
   localparam int CW  = $clog2(bbm_pkg::OUT_DEPTH + 1);
   localparam int PW  = $clog2(bbm_pkg::OUT_DEPTH);
   localparam int PXW = bbm_pkg::PIX_W;
   localparam int PRW = bbm_pkg::SUM_W + bbm_pkg::RECIP_W;

   logic [CW-1:0]  pend_ff, cnt_ff;
   logic [PW-1:0]  wr_ptr_ff, rd_ptr_ff;
   bbm_pkg::res_type fifo_ff [0:bbm_pkg::OUT_DEPTH-1];

   logic            b1_valid_ff, b2_valid_ff, b3_valid_ff;
   bbm_pkg::op_type b1_op_ff, b2_op_ff;
   logic            b3_row_end_ff, b3_frame_end_ff;
   logic [bbm_pkg::SUM_W-1:0]   b3_sum_ff [0:2];
   logic [bbm_pkg::RECIP_W-1:0] b3_recip_ff;

   logic                      last_we_ff;
   logic [bbm_pkg::COL_W-1:0] last_addr_ff;
   logic [2*PXW-1:0]          last_data_ff;
   logic [PXW-1:0]            win_ff [0:2][0:2];

   logic [2*PXW-1:0] rdata, lines;
   logic [PXW-1:0]   top, mid;
   logic             out_pop, push;
   logic [bbm_pkg::SUM_W-1:0] sum [0:2];
   logic [1:0]       ncols, nrows;
   logic [3:0]       n;
   logic [PRW-1:0]   prod [0:2];
   logic             col_en [0:2];
   logic             row_en [0:2];
   bbm_pkg::res_type res;

   assign out_pop = rsp_pop & ~rsp_empty;
   assign op_pop  = op_valid & (~op.has_res | (pend_ff < CW'(bbm_pkg::OUT_DEPTH)));

   bbm_ram #(
      .WIDTH(2 * PXW),
      .DEPTH(bbm_pkg::MAX_WIDTH)
   ) u_lines (
      .clock(clock),
      .we   (b1_valid_ff),
      .waddr(b1_op_ff.col),
      .wdata({mid, b1_op_ff.pixel}),
      .raddr(op.col),
      .rdata(rdata)
   );

   // the op just before may have written this column after the read
   assign lines = (last_we_ff && last_addr_ff == b1_op_ff.col) ? last_data_ff : rdata;
   assign top   = lines[2*PXW-1:PXW];
   assign mid   = lines[PXW-1:0];

   always_ff @(posedge clock) begin
      last_addr_ff <= b1_op_ff.col;
      last_data_ff <= {mid, b1_op_ff.pixel};
      b1_op_ff     <= op;
      b2_op_ff     <= b1_op_ff;
      if (b1_valid_ff) begin
         win_ff[0] <= win_ff[1];
         win_ff[1] <= win_ff[2];
         win_ff[2] <= '{top, mid, b1_op_ff.pixel};
      end
   end

   always_comb begin
      col_en = '{b2_op_ff.left_ok, 1'b1, b2_op_ff.right_ok};
      row_en = '{b2_op_ff.top_ok, 1'b1, b2_op_ff.bot_ok};
      ncols  = 2'd1 + {1'b0, b2_op_ff.left_ok} + {1'b0, b2_op_ff.right_ok};
      nrows  = 2'd1 + {1'b0, b2_op_ff.top_ok} + {1'b0, b2_op_ff.bot_ok};
      n      = {2'b00, ncols} * {2'b00, nrows};
      for (int ch = 0; ch < 3; ch++) begin
         sum[ch] = '0;
         for (int c = 0; c < 3; c++) begin
            for (int r = 0; r < 3; r++) begin
               if (col_en[c] && row_en[r]) begin
                  sum[ch] = sum[ch] + bbm_pkg::SUM_W'(win_ff[c][r][PXW-1-8*ch -: 8]);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      b3_sum_ff       <= sum;
      b3_recip_ff     <= bbm_pkg::recip(n);
      b3_row_end_ff   <= b2_op_ff.row_end;
      b3_frame_end_ff <= b2_op_ff.frame_end;
   end

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         prod[ch] = PRW'(b3_sum_ff[ch]) * PRW'(b3_recip_ff);
      end
      res.red       = prod[0][23:16];
      res.green     = prod[1][23:16];
      res.blue      = prod[2][23:16];
      res.row_end   = b3_row_end_ff;
      res.frame_end = b3_frame_end_ff;
      push          = b3_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff <= 1'b0;
         b2_valid_ff <= 1'b0;
         b3_valid_ff <= 1'b0;
         last_we_ff  <= 1'b0;
         pend_ff     <= '0;
         cnt_ff      <= '0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
      end else begin
         b1_valid_ff <= op_pop;
         b2_valid_ff <= b1_valid_ff & b1_op_ff.has_res;
         b3_valid_ff <= b2_valid_ff;
         last_we_ff  <= b1_valid_ff;
         pend_ff     <= pend_ff + CW'(op_pop & op.has_res) - CW'(out_pop);
         cnt_ff      <= cnt_ff + CW'(push) - CW'(out_pop);
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (out_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   assign rsp_empty       = (cnt_ff == '0);
   assign rsp             = fifo_ff[rd_ptr_ff];
   assign status.pend_cnt = pend_ff;
   assign status.fifo_cnt = cnt_ff;
endmodule

>>> hdl/box_blur_3x3_edge_mean.sv
// Top level of the 3x3 box blur with border-aware mean over RGB888 pixels.
`timescale 1ns / 1ps
// Streams RGB888 pixels in raster order and returns, per pixel, the truncated
// mean of each channel over the in-frame part of its 3x3 neighborhood. Result
// j comes out with input j + frame_width + 1; after the last pixel, drain
// items (req_type = 1) flush the pending results, one per drain. Throughput
// is one item per clock while req_full is low; a drain on a one-row frame
// steps the line-buffer port twice. Items pass the op queue, line-buffer read,
// window sum and reciprocal multiply to reach the rsp ports. Writing frame_width
// or frame_height restarts the frame; the user must write only while the block
// is idle; the block itself does not enforce this. Line buffers are not cleared;
// border neighbors are masked, so stale content never reaches a result.
`include "box_blur_3x3_edge_mean_assert.svh"
module box_blur_3x3_edge_mean (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_type,
   input  logic [7:0]  req_in_red,
   input  logic [7:0]  req_in_green,
   input  logic [7:0]  req_in_blue,
   // result channel
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_out_red,
   output logic [7:0]  rsp_out_green,
   output logic [7:0]  rsp_out_blue,
   output logic        rsp_row_end,
   output logic        rsp_frame_end,
   // configuration
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [12:0] csr_data
);
   logic [bbm_pkg::FW_W-1:0] fw_ff, fw_in;
   logic [bbm_pkg::FH_W-1:0] fh_ff, fh_in;
   logic                     csr_wr;
   logic                     op_valid, op_pop;
   bbm_pkg::op_type          op;
   bbm_pkg::res_type         rsp;
   bbm_pkg::status_type      status;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid & csr_ready;

   // out-of-range sizes clamp: zero to one, above the max to the max
   always_comb begin
      fw_in = fw_ff;
      fh_in = fh_ff;
      if (csr_wr && csr_index == bbm_pkg::CSR_FRAME_WIDTH) begin
         if (csr_data[10:0] == '0) begin
            fw_in = 11'd1;
         end else if (csr_data[10:0] > 11'(bbm_pkg::MAX_WIDTH)) begin
            fw_in = 11'(bbm_pkg::MAX_WIDTH);
         end else begin
            fw_in = csr_data[10:0];
         end
      end
      if (csr_wr && csr_index == bbm_pkg::CSR_FRAME_HEIGHT) begin
         if (csr_data == '0) begin
            fh_in = 13'd1;
         end else if (csr_data > 13'(bbm_pkg::MAX_HEIGHT)) begin
            fh_in = 13'(bbm_pkg::MAX_HEIGHT);
         end else begin
            fh_in = csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff <= 11'd640;
         fh_ff <= 13'd480;
      end else begin
         fw_ff <= fw_in;
         fh_ff <= fh_in;
      end
   end

   bbm_front u_front (
      .clock       (clock),
      .reset       (reset),
      .frame_width (fw_ff),
      .frame_height(fh_ff),
      .restart     (csr_wr),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_type    (req_type),
      .req_in_red  (req_in_red),
      .req_in_green(req_in_green),
      .req_in_blue (req_in_blue),
      .op_valid    (op_valid),
      .op          (op),
      .op_pop      (op_pop)
   );

   bbm_back u_back (
      .clock    (clock),
      .reset    (reset),
      .op_valid (op_valid),
      .op       (op),
      .op_pop   (op_pop),
      .rsp_empty(rsp_empty),
      .rsp_pop  (rsp_pop),
      .rsp      (rsp),
      .status   (status)
   );

   assign rsp_out_red   = rsp.red;
   assign rsp_out_green = rsp.green;
   assign rsp_out_blue  = rsp.blue;
   assign rsp_row_end   = rsp.row_end;
   assign rsp_frame_end = rsp.frame_end;

   // result queue never holds more than was granted credit for
   `BBM_ASSERT(a_fifo_le_credit, status.fifo_cnt <= status.pend_cnt)
   // credit never exceeds the result queue depth
   `BBM_ASSERT(a_credit_bound, status.pend_cnt <= 4'(bbm_pkg::OUT_DEPTH))
   // out of reset the result side is empty
   `BBM_ASSERT_ALL(a_empty_after_reset, reset |=> rsp_empty)
endmodule

>>> tb/sv/testbench.sv
// Testbench for the 3x3 box blur: random frames checked against a predictor.
`timescale 1ns / 1ps
module testbench;
   localparam int LIMIT = 2000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic        req_type = bbm_pkg::REQ_PIXEL;
   logic [7:0]  req_in_red = 8'd0;
   logic [7:0]  req_in_green = 8'd0;
   logic [7:0]  req_in_blue = 8'd0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [7:0]  rsp_out_red;
   logic [7:0]  rsp_out_green;
   logic [7:0]  rsp_out_blue;
   logic        rsp_row_end;
   logic        rsp_frame_end;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [0:0]  csr_index = bbm_pkg::CSR_FRAME_WIDTH;
   logic [12:0] csr_data = 13'd0;

   box_blur_3x3_edge_mean uut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // blur predictor state
   logic [23:0] upper_row [bbm_pkg::MAX_WIDTH];
   logic [23:0] middle_row [bbm_pkg::MAX_WIDTH];
   logic [23:0] win [9];
   int          next_col, next_row;
   int          width_now, height_now;
   bit          frame_closed;

   bbm_pkg::res_type blur_expected [$];
   int          errors = 0;
   int          cycles = 0;
   int          items_sent = 0;
   bit          idle_on = 1'b1;
   bit          long_hold_req = 1'b0;

   function automatic int clamp_dim(int v, int maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return v;
   endfunction

   function automatic void clear_frame();
      next_col = 0;
      next_row = 0;
      foreach (win[i]) win[i] = 24'd0;
   endfunction

   // Mean over the masked 3x3 window around window column 'center'.
   function automatic bbm_pkg::res_type blur_pixel(int center, bit left_ok, bit right_ok,
                                                   int orow, int ocol);
      bbm_pkg::res_type res;
      int      sum [3];
      int      cnt;
      bit      top_ok, bot_ok;
      sum = '{0, 0, 0};
      cnt = 0;
      top_ok = orow >= 1;
      bot_ok = orow + 1 < height_now;
      for (int c = center - 1; c <= center + 1; c++) begin
         if ((c < center && !left_ok) || (c > center && !right_ok)) continue;
         for (int r = 0; r < 3; r++) begin
            if ((r == 0 && !top_ok) || (r == 2 && !bot_ok)) continue;
            sum[0] += win[c*3+r][23:16];
            sum[1] += win[c*3+r][15:8];
            sum[2] += win[c*3+r][7:0];
            cnt++;
         end
      end
      res.red       = 8'(sum[0] / cnt);
      res.green     = 8'(sum[1] / cnt);
      res.blue      = 8'(sum[2] / cnt);
      res.row_end   = (ocol + 1 == width_now);
      res.frame_end = res.row_end && (orow + 1 == height_now);
      return res;
   endfunction

   // One stream position, real pixel or phantom; queues a result if one forms.
   function automatic bit blur_advance(logic [23:0] px);
      int          x;
      logic [23:0] top, mid;
      bbm_pkg::res_type res;
      bit          made;
      x = next_col % bbm_pkg::MAX_WIDTH;
      top = upper_row[x];
      mid = middle_row[x];
      made = 1'b0;
      upper_row[x] = mid;
      middle_row[x] = px;
      if (x == 0 && next_row >= 2) begin
         res = blur_pixel(2, width_now >= 2, 1'b0, next_row - 2, width_now - 1);
         made = 1'b1;
      end
      for (int i = 0; i < 6; i++) win[i] = win[i+3];
      win[6] = top;
      win[7] = mid;
      win[8] = px;
      if (x != 0 && next_row >= 1) begin
         res = blur_pixel(1, x >= 2, 1'b1, next_row - 1, x - 1);
         made = 1'b1;
      end
      next_col++;
      if (next_col >= width_now) begin
         next_col = 0;
         next_row++;
      end
      if (made) begin
         blur_expected.push_back(res);
         if (res.frame_end) begin
            frame_closed = 1'b1;
            clear_frame();
         end
      end
      return made;
   endfunction

   function automatic void blur_accept(logic kind, logic [23:0] px);
      if (kind == bbm_pkg::REQ_PIXEL) begin
         if (next_row < height_now) void'(blur_advance(px));
      end else if (next_row >= height_now) begin
         // one-row frames pass a phantom position first
         if (!blur_advance(24'd0)) void'(blur_advance(24'd0));
      end
   endfunction

   // Drive one item and hold it until the transfer; optional idle burst first.
   task automatic send_item(logic kind, logic [7:0] r, logic [7:0] g, logic [7:0] b);
      if (idle_on && $urandom_range(0, 9) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_push     <= 1'b1;
      req_type     <= kind;
      req_in_red   <= r;
      req_in_green <= g;
      req_in_blue  <= b;
      do @(posedge clock); while (req_full);
      blur_accept(kind, {r, g, b});
      items_sent++;
   endtask

   task automatic wait_idle();
      req_push <= 1'b0;
      while (blur_expected.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);   // covers the four-stage pipe
   endtask

   task automatic write_reg(logic [0:0] idx, logic [12:0] value);
      wait_idle();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == bbm_pkg::CSR_FRAME_WIDTH)
         width_now = clamp_dim(value & 13'h7ff, bbm_pkg::MAX_WIDTH);
      else height_now = clamp_dim(value, bbm_pkg::MAX_HEIGHT);
      clear_frame();
      @(posedge clock);
   endtask

   function automatic logic [7:0] rand_chan(bit edges);
      if (edges) return $urandom_range(0, 1) ? 8'hff : 8'h00;
      return 8'($urandom);
   endfunction

   // One whole frame; noise adds ignored drains and pixels at the edges.
   task automatic run_frame(bit edges, bit noise);
      frame_closed = 1'b0;
      for (int i = 0; i < width_now * height_now; i++) begin
         if (noise && $urandom_range(0, 15) == 0)
            send_item(bbm_pkg::REQ_DRAIN, 8'($urandom), 8'd0, 8'd0);
         send_item(bbm_pkg::REQ_PIXEL, rand_chan(edges), rand_chan(edges), rand_chan(edges));
      end
      if (noise) send_item(bbm_pkg::REQ_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
      while (!frame_closed)
         send_item(bbm_pkg::REQ_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
      if (noise) send_item(bbm_pkg::REQ_DRAIN, 8'd0, 8'd0, 8'd0);
   endtask

   task automatic set_geometry(int w, int h);
      write_reg(bbm_pkg::CSR_FRAME_WIDTH, 13'(w));
      write_reg(bbm_pkg::CSR_FRAME_HEIGHT, 13'(h));
   endtask

   // Saturated channels, early/late drains and stray pixels on a 3x3 frame.
   task automatic test_directed();
      set_geometry(3, 3);
      send_item(bbm_pkg::REQ_DRAIN, 8'd0, 8'd0, 8'd0);   // before any pixel: ignored
      run_frame(1'b1, 1'b1);
   endtask

   // Zero stores as one: single-pixel frame, and one-row and one-column frames.
   task automatic test_tiny_frames();
      set_geometry(0, 0);
      run_frame(1'b1, 1'b1);
      set_geometry(5, 1);
      run_frame(1'b0, 1'b1);
      set_geometry(1, 6);
      run_frame(1'b0, 1'b1);
   endtask

   // Oversized values clamp to the maxima; the first results of a partial
   // frame only line up when the width is clamped to the maximum.
   task automatic test_clamp();
      set_geometry(2047, 8191);
      for (int i = 0; i < bbm_pkg::MAX_WIDTH + 4; i++) begin
         send_item(bbm_pkg::REQ_PIXEL, rand_chan(1'b0), rand_chan(1'b0), rand_chan(1'b0));
      end
      wait_idle();
   endtask

   // Long result-side hold while pixels keep coming, so the input backs up.
   task automatic test_backpressure();
      set_geometry(8, 6);
      long_hold_req = 1'b1;
      run_frame(1'b0, 1'b0);
   endtask

   task automatic test_random();
      int start;
      start = items_sent;
      while (items_sent - start < 150) begin
         if ($urandom_range(0, 2) == 0 || items_sent == start)
            set_geometry($urandom_range(1, 12), $urandom_range(1, 8));
         run_frame(1'b0, $urandom_range(0, 3) == 0);
      end
   endtask

   task automatic test_no_idle();
      wait_idle();
      idle_on = 1'b0;
      set_geometry(7, 5);
      run_frame(1'b0, 1'b0);
      run_frame(1'b0, 1'b1);
   endtask

   // Result side: check each transfer, then pick pop for the next edge.
   int hold_cnt = 0;
   bit hold_done = 1'b0;
   always @(posedge clock) begin
      bbm_pkg::res_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (blur_expected.size() == 0) begin
            $display("%t: unexpected result r=%0d g=%0d b=%0d", $realtime,
                     rsp_out_red, rsp_out_green, rsp_out_blue);
            errors++;
         end else begin
            want = blur_expected.pop_front();
            if ({rsp_out_red, rsp_out_green, rsp_out_blue, rsp_row_end, rsp_frame_end}
                != want) begin
               $display("%t: mismatch expected r=%0d g=%0d b=%0d re=%0d fe=%0d",
                        $realtime, want.red, want.green, want.blue,
                        want.row_end, want.frame_end);
               $display("%t:          actual   r=%0d g=%0d b=%0d re=%0d fe=%0d",
                        $realtime, rsp_out_red, rsp_out_green, rsp_out_blue,
                        rsp_row_end, rsp_frame_end);
               errors++;
            end
         end
      end
      if (long_hold_req && !hold_done) begin
         hold_done = 1'b1;
         hold_cnt = 300;
      end
      if (hold_cnt > 0) begin
         hold_cnt--;
         rsp_pop <= 1'b0;
      end else if (idle_on && !reset && $urandom_range(0, 9) == 0) begin
         hold_cnt = $urandom_range(1, 16);
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      foreach (upper_row[i]) upper_row[i] = 24'd0;
      foreach (middle_row[i]) middle_row[i] = 24'd0;
      width_now = 640;
      height_now = 480;
      clear_frame();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_tiny_frames();
      test_clamp();
      test_backpressure();
      test_random();
      test_no_idle();
      wait_idle();
      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule

>>> box_blur_3x3_edge_mean.f
+incdir+hdl
hdl/bbm_pkg.sv
hdl/bbm_ram.sv
hdl/bbm_front.sv
hdl/bbm_back.sv
hdl/box_blur_3x3_edge_mean.sv
tb/sv/testbench.sv
